// File: design/ifr_pkg.sv
package ifr_pkg;

    localparam int NUM_CHANNELS = 14;
    localparam int FRAME_BYTES  = 32;
    localparam int STORE_DEPTH  = 14;
    localparam int FS_CH        = 10;
    localparam int PAYLOAD_CH   = (FRAME_BYTES - 4) / 2;
    localparam int NUM_OUT      = (PAYLOAD_CH < NUM_CHANNELS) ? PAYLOAD_CH : NUM_CHANNELS;

    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 12;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 5;
    localparam int CH_W    = 4;
    localparam int RAM_DEPTH = 2 * (1 << CH_W);
    localparam int RAM_AW    = CH_W + 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int PEND_W     = 2;

    localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;
    localparam logic [SUM_W-1:0]  SUM_INIT    = 16'hFFFF;

    localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] REG_FS_THRESHOLD  = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd32;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd64;
    localparam logic [VAL_W-1:0]  FS_THRESHOLD_RST  = 12'd1500;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [VAL_W-1:0]  fs_threshold;
    } t_cfg;

    typedef struct packed {
        logic bank;
        logic error;
        logic failsafe;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_ram_wr;

    typedef struct packed {
        logic done;
    } t_back_stat;

endpackage

// File: design/ifr_if.sv
interface ifr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, rx_byte, input ready);
    modport sink   (input valid, rx_byte, output ready);
endinterface

interface ifr_res_if;
    logic        valid;
    logic        ready;
    logic        result_type;
    logic [3:0]  channel_index;
    logic [11:0] channel_value;
    logic        failsafe;
    logic        last;
    modport source (output valid, result_type, channel_index, channel_value, failsafe, last,
                    input ready);
    modport sink   (input valid, result_type, channel_index, channel_value, failsafe, last,
                    output ready);
endinterface

interface ifr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [11:0] wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: design/ifr_ram.sv
module ifr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ifr_front.sv
module ifr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ifr_byte_if.sink            i_rx,
    input  ifr_pkg::t_cfg       i_cfg,
    input  ifr_pkg::t_back_stat i_back,
    output ifr_pkg::t_ram_wr    o_wr,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output ifr_pkg::t_cmd       o_push_cmd
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_SECOND  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CHECK   = 4'b1000
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [ifr_pkg::CNT_W-1:0]       r_count, n_count;
    logic [ifr_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic [ifr_pkg::BYTE_W-1:0]      r_low, n_low;
    logic [ifr_pkg::VAL_W-1:0]       r_fs_val, n_fs_val;
    logic                            r_bank, n_bank;
    logic [ifr_pkg::PEND_W-1:0]      r_pending, n_pending;

    logic                            w_acc;
    logic [ifr_pkg::BYTE_W-1:0]      w_b;
    logic [ifr_pkg::CNT_W-1:0]       w_p;
    logic [ifr_pkg::CH_W-1:0]        w_ch;
    logic [ifr_pkg::SUM_W-1:0]       w_sum_sub;

    assign i_rx.ready = (r_pending < ifr_pkg::PEND_W'(ifr_pkg::FIFO_DEPTH)) && i_push_ready;
    assign w_acc      = i_rx.valid && i_rx.ready;
    assign w_b        = i_rx.rx_byte;
    assign w_p        = r_count - ifr_pkg::CNT_W'(2);
    assign w_ch       = w_p[ifr_pkg::CNT_W-1:1];
    assign w_sum_sub  = r_sum - {{(ifr_pkg::SUM_W-ifr_pkg::BYTE_W){1'b0}}, w_b};

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_sum      = r_sum;
        n_low      = r_low;
        n_fs_val   = r_fs_val;
        n_bank     = r_bank;
        o_wr.we    = 1'b0;
        o_wr.addr  = {w_ch, r_bank};
        o_wr.data  = {w_b[ifr_pkg::CH_W-1:0] & ifr_pkg::NIBBLE_MASK[ifr_pkg::CH_W-1:0], r_low};
        o_push_valid        = 1'b0;
        o_push_cmd.bank     = r_bank;
        o_push_cmd.error    = ({w_b, r_low} != r_sum);
        o_push_cmd.failsafe = (ifr_pkg::NUM_OUT > ifr_pkg::FS_CH) &&
                              (r_fs_val > i_cfg.fs_threshold);
        if (w_acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_b == i_cfg.header_first) begin
                        n_sum   = ifr_pkg::SUM_INIT -
                                  {{(ifr_pkg::SUM_W-ifr_pkg::BYTE_W){1'b0}}, w_b};
                        n_count = ifr_pkg::CNT_W'(1);
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (w_b == i_cfg.header_second) begin
                        n_sum   = w_sum_sub;
                        n_count = ifr_pkg::CNT_W'(2);
                        n_phase = (ifr_pkg::FRAME_BYTES > 4) ? PH_PAYLOAD : PH_CHECK;
                    end else begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_sum   = ifr_pkg::SUM_INIT;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum = w_sum_sub;
                    if (!w_p[0]) begin
                        n_low = w_b;
                    end else if (w_ch < ifr_pkg::CH_W'(ifr_pkg::STORE_DEPTH)) begin
                        o_wr.we = 1'b1;
                        if (w_ch == ifr_pkg::CH_W'(ifr_pkg::FS_CH)) begin
                            n_fs_val = o_wr.data;
                        end
                    end
                    n_count = r_count + ifr_pkg::CNT_W'(1);
                    if (n_count >= ifr_pkg::CNT_W'(ifr_pkg::FRAME_BYTES - 2)) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (r_count < ifr_pkg::CNT_W'(ifr_pkg::FRAME_BYTES - 1)) begin
                        n_low   = w_b;
                        n_count = r_count + ifr_pkg::CNT_W'(1);
                    end else begin
                        o_push_valid = 1'b1;
                        n_bank       = ~r_bank;
                        n_phase      = PH_HUNT;
                        n_count      = '0;
                        n_sum        = ifr_pkg::SUM_INIT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // frames owned by the queue or the back end; each holds one store bank
    always_comb begin
        n_pending = r_pending;
        case ({o_push_valid, i_back.done})
            2'b10:   n_pending = r_pending + ifr_pkg::PEND_W'(1);
            2'b01:   n_pending = r_pending - ifr_pkg::PEND_W'(1);
            default: n_pending = r_pending;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_sum     <= ifr_pkg::SUM_INIT;
            r_bank    <= 1'b0;
            r_pending <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_bank    <= n_bank;
            r_pending <= n_pending;
        end
        r_low    <= n_low;
        r_fs_val <= n_fs_val;
    end

endmodule

// File: design/ifr_cmd_fifo.sv
module ifr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ifr_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ifr_pkg::t_cmd o_pop_cmd
);

    localparam int CNT_W = $clog2(ifr_pkg::FIFO_DEPTH + 1);

    ifr_pkg::t_cmd                r_mem [ifr_pkg::FIFO_DEPTH];
    logic [ifr_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]             r_cnt;
    logic                         w_push, w_pop;

    assign o_push_ready = (r_cnt != CNT_W'(ifr_pkg::FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + ifr_pkg::FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + ifr_pkg::FIFO_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

// File: design/ifr_back.sv
module ifr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pop_valid,
    output logic                        o_pop_ready,
    input  ifr_pkg::t_cmd               i_pop_cmd,
    output logic [ifr_pkg::RAM_AW-1:0]  o_raddr,
    input  logic [ifr_pkg::VAL_W-1:0]   i_rdata,
    output ifr_pkg::t_back_stat         o_stat,
    ifr_res_if.source                   o_res
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_SEND  = 3'b100
    } t_bstate;

    t_bstate                      r_state, n_state;
    logic [ifr_pkg::CH_W-1:0]     r_k, n_k;
    logic                         r_bank, n_bank;
    logic                         r_fs, n_fs;
    logic                         r_valid, n_valid;
    logic                         r_type, n_type;
    logic [ifr_pkg::CH_W-1:0]     r_idx, n_idx;
    logic [ifr_pkg::VAL_W-1:0]    r_val, n_val;
    logic                         r_fs_out, n_fs_out;
    logic                         r_last, n_last;

    assign o_pop_ready = (r_state == B_IDLE);
    assign o_raddr     = {n_k, n_bank};

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_bank   = r_bank;
        n_fs     = r_fs;
        n_valid  = r_valid;
        n_type   = r_type;
        n_idx    = r_idx;
        n_val    = r_val;
        n_fs_out = r_fs_out;
        n_last   = r_last;
        o_stat.done = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_pop_valid) begin
                    n_bank = i_pop_cmd.bank;
                    n_fs   = i_pop_cmd.failsafe;
                    n_k    = '0;
                    if (i_pop_cmd.error) begin
                        n_valid  = 1'b1;
                        n_type   = 1'b1;
                        n_idx    = '0;
                        n_val    = '0;
                        n_fs_out = 1'b0;
                        n_last   = 1'b1;
                        n_state  = B_SEND;
                    end else begin
                        n_state = B_FETCH;
                    end
                end
            end
            B_FETCH: begin
                n_valid  = 1'b1;
                n_type   = 1'b0;
                n_idx    = r_k;
                n_val    = i_rdata;
                n_fs_out = r_fs;
                n_last   = (r_k == ifr_pkg::CH_W'(ifr_pkg::NUM_OUT - 1));
                n_state  = B_SEND;
            end
            B_SEND: begin
                if (o_res.ready) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        o_stat.done = 1'b1;
                        n_state     = B_IDLE;
                    end else begin
                        n_k     = r_k + ifr_pkg::CH_W'(1);
                        n_state = B_FETCH;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_k     <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_k     <= n_k;
            r_bank  <= n_bank;
        end
        r_fs     <= n_fs;
        r_type   <= n_type;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_fs_out <= n_fs_out;
        r_last   <= n_last;
    end

    assign o_res.valid         = r_valid;
    assign o_res.result_type   = r_type;
    assign o_res.channel_index = r_idx;
    assign o_res.channel_value = r_val;
    assign o_res.failsafe      = r_fs_out;
    assign o_res.last          = r_last;

endmodule

// File: design/ibus_frame_receiver_core.sv
// Byte input: one word per cycle while fewer than two finished frames are held for output.
// Frame results start once the frame's command has passed the queue and the back end has read
// its first channel from the store; the back end then sends the 14 channels one by one, each
// a store read and output register, held until taken. A checksum error gives one result word.
// Synchronous active-low reset: parser back to header hunt, queue empty, registers to defaults.
module ibus_frame_receiver_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifr_cfg_if.sink   i_cfg,
    ifr_byte_if.sink  i_rx,
    ifr_res_if.source o_res
);

    ifr_pkg::t_cfg                   r_cfg;
    ifr_pkg::t_ram_wr                w_wr;
    ifr_pkg::t_cmd                   w_push_cmd, w_pop_cmd;
    ifr_pkg::t_back_stat             w_back;
    logic                            w_push_valid, w_push_ready;
    logic                            w_pop_valid, w_pop_ready;
    logic [ifr_pkg::RAM_AW-1:0]      w_raddr;
    logic [ifr_pkg::VAL_W-1:0]       w_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= ifr_pkg::HEADER_FIRST_RST;
            r_cfg.header_second <= ifr_pkg::HEADER_SECOND_RST;
            r_cfg.fs_threshold  <= ifr_pkg::FS_THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                ifr_pkg::REG_HEADER_FIRST:
                    r_cfg.header_first <= i_cfg.wr_data[ifr_pkg::BYTE_W-1:0];
                ifr_pkg::REG_HEADER_SECOND:
                    r_cfg.header_second <= i_cfg.wr_data[ifr_pkg::BYTE_W-1:0];
                ifr_pkg::REG_FS_THRESHOLD:
                    r_cfg.fs_threshold <= i_cfg.wr_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    ifr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_cfg        (r_cfg),
        .i_back       (w_back),
        .o_wr         (w_wr),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    ifr_ram #(
        .WIDTH (ifr_pkg::VAL_W),
        .DEPTH (ifr_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ifr_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    ifr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_cmd   (w_pop_cmd),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_stat      (w_back),
        .o_res       (o_res)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> w_push_ready)
        else $error("frame command pushed into a full queue");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.result_type) |->
            (o_res.last && o_res.channel_value == '0 && !o_res.failsafe))
        else $error("checksum error word malformed");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.result_type) |->
            (o_res.channel_index < ifr_pkg::CH_W'(ifr_pkg::NUM_OUT)))
        else $error("channel index out of range");

    a_done_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back.done |-> !w_pop_ready)
        else $error("frame done while back end idle");

endmodule
